FILE: sv/operand_stack_machine_defines.svh
// ----------------------------------------------------------------------------
// Operand stack machine assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef OPERAND_STACK_MACHINE_DEFINES_SVH
`define OPERAND_STACK_MACHINE_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define OSM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("operand stack check failed");

// cons must hold in the same cycle as ante
`define OSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("operand stack check failed");

// cons must hold in the cycle after ante
`define OSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("operand stack check failed");

`endif

FILE: sv/osm_pkg.sv
// ----------------------------------------------------------------------------
// Operand stack machine package
// Command and status codes, field widths and shared structs.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int WORD_W      = 64;
    localparam int CMD_W       = 4;
    localparam int TAKE_W      = 7;
    localparam int FILL_W      = 7;
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_ONE = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PUSH_VAL = 4'd3;
    localparam logic [CMD_W-1:0] CMD_OUTPUT   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DUP      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SWAP     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ROT      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REVROT   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MUL      = 4'd10;
    localparam logic [CMD_W-1:0] CMD_NEG      = 4'd11;
    localparam logic [CMD_W-1:0] CMD_OUTK     = 4'd12;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // work classes handed from the front end to the execution side
    typedef enum logic [3:0] {
        K_RESULT   = 4'd0,
        K_WRITE    = 4'd1,
        K_READ_OUT = 4'd2,
        K_DUP      = 4'd3,
        K_NEG      = 4'd4,
        K_MOVE     = 4'd5,
        K_SWAP     = 4'd6,
        K_ADD      = 4'd7,
        K_MUL      = 4'd8,
        K_OUTK     = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STATUS_W-1:0]  status;
        logic [FILL_W-1:0]    fill;
        logic [TAKE_W-1:0]    take;
        logic [WORD_W-1:0]    value;
    } t_op;

    typedef struct packed {
        logic [WORD_W-1:0]    word;
        logic                 word_valid;
        logic [STATUS_W-1:0]  status;
        logic                 last;
        logic [FILL_W-1:0]    fill;
    } t_res;

endpackage

FILE: sv/osm_if.sv
// ----------------------------------------------------------------------------
// Operand stack machine channels
// Command request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface osm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [osm_pkg::CMD_W-1:0]    cmd;
    logic signed [osm_pkg::WORD_W-1:0]   push_value;
    logic        [osm_pkg::TAKE_W-1:0]   take_count;

    modport source (output valid, cmd, push_value, take_count, input ready);
    modport sink   (input valid, cmd, push_value, take_count, output ready);
endinterface

interface osm_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [osm_pkg::WORD_W-1:0]   word_out;
    logic                                word_valid;
    logic        [osm_pkg::STATUS_W-1:0] status;
    logic                                last;
    logic        [osm_pkg::FILL_W-1:0]   fill_level;

    modport source (output valid, word_out, word_valid, status, last, fill_level,
                    input ready);
    modport sink   (input valid, word_out, word_valid, status, last, fill_level,
                    output ready);
endinterface

FILE: sv/osm_front.sv
// ----------------------------------------------------------------------------
// Operand stack front end
// Tracks fill count and bottom slot, checks each command and turns it into
// a work entry with resolved slot addresses.
// ----------------------------------------------------------------------------
module osm_front #(
    parameter  int STACK_DEPTH = 64,
    localparam int AW          = $clog2(STACK_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    osm_cmd_if.sink        i_cmd,
    output logic           o_op_valid,
    input  logic           i_op_ready,
    output osm_pkg::t_op   o_op,
    output logic [AW-1:0]  o_slot_a,
    output logic [AW-1:0]  o_slot_b
);
    import osm_pkg::*;

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = (CW > TAKE_W) ? CW : TAKE_W;

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_bottom, n_bottom;

    logic          accept;
    logic          full, empty, few, k_bad;
    logic [CW-1:0] count_m1, count_m2;
    logic [AW-1:0] slot_top, slot_second, slot_next, bottom_dec, bottom_inc;

    // base < depth and, wherever the result is used, pos <= depth, so one conditional subtract wraps it
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(pos);
        if (sum >= (CW+1)'(STACK_DEPTH)) begin
            sum = sum - (CW+1)'(STACK_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = i_op_ready;
    assign o_op_valid = i_cmd.valid;

    assign full     = (r_count == CW'(STACK_DEPTH));
    assign empty    = (r_count == '0);
    assign few      = (r_count < CW'(2));
    assign count_m1 = r_count - CW'(1);
    assign count_m2 = r_count - CW'(2);

    assign slot_top    = slot_of(r_bottom, count_m1);
    assign slot_second = slot_of(r_bottom, count_m2);
    assign slot_next   = slot_of(r_bottom, r_count);
    assign bottom_dec  = (r_bottom == '0) ? AW'(STACK_DEPTH - 1) : r_bottom - AW'(1);
    assign bottom_inc  = (r_bottom == AW'(STACK_DEPTH - 1)) ? '0 : r_bottom + AW'(1);

    assign k_bad = (CMPW'(i_cmd.take_count) > CMPW'(r_count)) ||
                   (i_cmd.take_count > TAKE_W'(MAX_RESULTS));

    always_comb begin
        n_count     = r_count;
        n_bottom    = r_bottom;
        o_op.kind   = K_RESULT;
        o_op.status = ST_OK;
        o_op.take   = i_cmd.take_count;
        o_op.value  = i_cmd.push_value;
        o_slot_a    = slot_top;
        o_slot_b    = slot_second;

        case (i_cmd.cmd)
            CMD_PUSH_ONE, CMD_PUSH_VAL: begin
                if (full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_op.kind = K_WRITE;
                    o_slot_a  = slot_next;
                    n_count   = r_count + CW'(1);
                    if (i_cmd.cmd == CMD_PUSH_ONE) begin
                        o_op.value = WORD_W'(1);
                    end
                end
            end
            CMD_POP: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    n_count = count_m1;
                end
            end
            CMD_PEEK, CMD_OUTPUT: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = K_READ_OUT;
                    if (i_cmd.cmd == CMD_OUTPUT) begin
                        n_count = count_m1;
                    end
                end
            end
            CMD_DUP: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else if (full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_op.kind = K_DUP;
                    o_slot_b  = slot_next;
                    n_count   = r_count + CW'(1);
                end
            end
            CMD_SWAP, CMD_ADD, CMD_MUL: begin
                if (few) begin
                    o_op.status = ST_FEW;
                end else if (i_cmd.cmd == CMD_SWAP) begin
                    o_op.kind = K_SWAP;
                end else begin
                    o_op.kind = (i_cmd.cmd == CMD_ADD) ? K_ADD : K_MUL;
                    n_count   = count_m1;
                end
            end
            CMD_ROT: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = K_MOVE;
                    o_slot_b  = bottom_dec;
                    n_bottom  = bottom_dec;
                end
            end
            CMD_REVROT: begin
                // bottom word lands one past the old top
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = K_MOVE;
                    o_slot_a  = r_bottom;
                    o_slot_b  = slot_next;
                    n_bottom  = bottom_inc;
                end
            end
            CMD_NEG: begin
                if (empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = K_NEG;
                end
            end
            CMD_OUTK: begin
                if (k_bad) begin
                    o_op.status = ST_FEW;
                end else if (i_cmd.take_count != '0) begin
                    o_op.kind = K_OUTK;
                    n_count   = CW'(CMPW'(r_count) - CMPW'(i_cmd.take_count));
                end
            end
            default: begin
            end
        endcase

        o_op.fill = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bottom <= '0;
        end else if (accept) begin
            r_count  <= n_count;
            r_bottom <= n_bottom;
        end
    end

endmodule

FILE: sv/osm_queue.sv
// ----------------------------------------------------------------------------
// Operand stack work queue
// Small register FIFO between front end and execution side.
// ----------------------------------------------------------------------------
module osm_queue #(
    parameter int W = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  logic [W-1:0]  i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output logic [W-1:0]  o_rd_data
);
    import osm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_entry [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_used, n_used;
    logic          push, pop;

    assign o_wr_ready = (r_used != NW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_used != '0);
    assign o_rd_data  = r_entry[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_used = r_used + NW'(1);
        end else if (pop && !push) begin
            n_used = r_used - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: sv/osm_back.sv
// ----------------------------------------------------------------------------
// Operand stack execution side
// Word memory, sequencer for reads, writes and the split multiply, and the
// result output register.
// ----------------------------------------------------------------------------
module osm_back #(
    parameter  int STACK_DEPTH = 64,
    localparam int AW          = $clog2(STACK_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    input  osm_pkg::t_op   i_op,
    input  logic [AW-1:0]  i_slot_a,
    input  logic [AW-1:0]  i_slot_b,
    osm_res_if.source      o_res
);
    import osm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_A    = 7'b0000010,
        S_B    = 7'b0000100,
        S_SWAP = 7'b0001000,
        S_MUL1 = 7'b0010000,
        S_MUL2 = 7'b0100000,
        S_OUTK = 7'b1000000
    } t_bstate;

    t_bstate             r_state, n_state;
    t_op                 r_op, n_op;
    logic [AW-1:0]       r_slot_a, n_slot_a;
    logic [AW-1:0]       r_slot_b, n_slot_b;
    logic [TAKE_W-1:0]   r_left, n_left;
    logic [WORD_W-1:0]   r_a, n_a;
    logic [WORD_W-1:0]   r_b, n_b;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    logic [WORD_W-1:0]   r_store [STACK_DEPTH];
    logic [WORD_W-1:0]   r_rdata;
    logic                mem_re, mem_we;
    logic [AW-1:0]       mem_raddr, mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic                out_free, emit;
    t_res                res;
    logic [31:0]         mul_x, mul_y;
    logic [63:0]         mul_p;
    logic [AW-1:0]       slot_down;

    assign out_free  = !r_out_valid || o_res.ready;
    assign slot_down = (r_slot_a == '0) ? AW'(STACK_DEPTH - 1) : r_slot_a - AW'(1);
    assign mul_p     = mul_x * mul_y;

    // one 32x32 multiplier, fed a different partial product each step
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_x = r_a[31:0];
                mul_y = r_b[63:32];
            end
            S_MUL2: begin
                mul_x = r_a[63:32];
                mul_y = r_b[31:0];
            end
            default: begin
                mul_x = r_a[31:0];
                mul_y = r_rdata[31:0];
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_slot_a       = r_slot_a;
        n_slot_b       = r_slot_b;
        n_left         = r_left;
        n_a            = r_a;
        n_b            = r_b;
        n_acc          = r_acc;
        o_op_ready     = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = r_slot_b;
        mem_we         = 1'b0;
        mem_waddr      = r_slot_b;
        mem_wdata      = r_rdata;
        emit           = 1'b0;
        res.word       = '0;
        res.word_valid = 1'b0;
        res.status     = r_op.status;
        res.last       = 1'b1;
        res.fill       = r_op.fill;

        case (r_state)
            S_IDLE: begin
                res.status = i_op.status;
                res.fill   = i_op.fill;
                if (i_op_valid) begin
                    case (i_op.kind)
                        K_RESULT: begin
                            if (out_free) begin
                                o_op_ready = 1'b1;
                                emit       = 1'b1;
                            end
                        end
                        K_WRITE: begin
                            if (out_free) begin
                                o_op_ready = 1'b1;
                                emit       = 1'b1;
                                mem_we     = 1'b1;
                                mem_waddr  = i_slot_a;
                                mem_wdata  = i_op.value;
                            end
                        end
                        default: begin
                            o_op_ready = 1'b1;
                            n_op       = i_op;
                            n_slot_a   = i_slot_a;
                            n_slot_b   = i_slot_b;
                            n_left     = i_op.take;
                            mem_re     = 1'b1;
                            mem_raddr  = i_slot_a;
                            n_state    = (i_op.kind == K_OUTK) ? S_OUTK : S_A;
                        end
                    endcase
                end
            end
            S_A: begin
                case (r_op.kind)
                    K_READ_OUT: begin
                        if (out_free) begin
                            emit           = 1'b1;
                            res.word       = r_rdata;
                            res.word_valid = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    K_DUP, K_MOVE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            mem_we  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_NEG: begin
                        if (out_free) begin
                            emit      = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = r_slot_a;
                            mem_wdata = '0 - r_rdata;
                            n_state   = S_IDLE;
                        end
                    end
                    default: begin
                        n_a     = r_rdata;
                        mem_re  = 1'b1;
                        n_state = S_B;
                    end
                endcase
            end
            S_B: begin
                case (r_op.kind)
                    K_SWAP: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_slot_a;
                        n_state   = S_SWAP;
                    end
                    K_ADD: begin
                        if (out_free) begin
                            emit      = 1'b1;
                            mem_we    = 1'b1;
                            mem_wdata = r_a + r_rdata;
                            n_state   = S_IDLE;
                        end
                    end
                    default: begin
                        n_acc   = mul_p;
                        n_b     = r_rdata;
                        n_state = S_MUL1;
                    end
                endcase
            end
            S_SWAP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = r_a;
                    n_state   = S_IDLE;
                end
            end
            S_MUL1: begin
                n_acc   = r_acc + {mul_p[31:0], 32'd0};
                n_state = S_MUL2;
            end
            S_MUL2: begin
                if (out_free) begin
                    emit      = 1'b1;
                    mem_we    = 1'b1;
                    mem_wdata = r_acc + {mul_p[31:0], 32'd0};
                    n_state   = S_IDLE;
                end
            end
            S_OUTK: begin
                // one word per cycle while the output register is free, walking down from the old top
                res.word       = r_rdata;
                res.word_valid = 1'b1;
                res.last       = (r_left == TAKE_W'(1));
                if (out_free) begin
                    emit = 1'b1;
                    if (res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = slot_down;
                        n_slot_a  = slot_down;
                        n_left    = r_left - TAKE_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out       = emit ? res : r_out;
        n_out_valid = emit || (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_slot_a <= n_slot_a;
        r_slot_b <= n_slot_b;
        r_left   <= n_left;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_raddr];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.word_out   = r_out.word;
    assign o_res.word_valid = r_out.word_valid;
    assign o_res.status     = r_out.status;
    assign o_res.last       = r_out.last;
    assign o_res.fill_level = r_out.fill;

endmodule

FILE: sv/operand_stack_machine.sv
// ----------------------------------------------------------------------------
// Operand stack machine
// Ring-buffer operand stack of signed 64-bit words driven by command requests.
// ----------------------------------------------------------------------------
// The front end takes one command request per cycle while its two-entry work
// queue has room; it checks stack depth, updates the fill count and resolves
// slot addresses, so error and pop requests cost it nothing extra. The
// execution side owns the word memory (one read and one write port, read data
// registered) and paces the requests by the memory reads, writes and multiply
// steps that each needs; multiply forms three 32x32 partial products on one
// multiplier, and output-k returns one word per cycle after the first read
// while the output register is free. Results leave through an output register,
// so while a result waits to be taken the sequencer goes on with the next
// request up to the step that produces its own result. The memory needs no
// clearing after reset; only slots holding stack words are ever read.
// fill_level carries the low 7 bits of the word count.
module operand_stack_machine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    osm_cmd_if.sink    i_cmd,
    osm_res_if.source  o_res
);
    import osm_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int OW = $bits(t_op);
    localparam int QW = OW + 2 * AW;

    logic          front_valid, front_ready;
    t_op           front_op;
    logic [AW-1:0] front_slot_a, front_slot_b;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    t_op           back_op;
    logic [AW-1:0] back_slot_a, back_slot_b;

    osm_front #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_op_valid (front_valid),
        .i_op_ready (front_ready),
        .o_op       (front_op),
        .o_slot_a   (front_slot_a),
        .o_slot_b   (front_slot_b)
    );

    osm_queue #(
        .W (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_data  ({front_op, front_slot_a, front_slot_b}),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_data)
    );

    assign back_op     = q_data[QW-1 -: OW];
    assign back_slot_a = q_data[2*AW-1 -: AW];
    assign back_slot_b = q_data[AW-1:0];

    osm_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .o_op_ready (q_ready),
        .i_op       (back_op),
        .i_slot_a   (back_slot_a),
        .i_slot_b   (back_slot_b),
        .o_res      (o_res)
    );

endmodule

FILE: sv/osm_checker.sv
// ----------------------------------------------------------------------------
// Operand stack machine port checker
// Result channel checks, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "operand_stack_machine_defines.svh"

module osm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [osm_pkg::WORD_W-1:0]    i_word_out,
    input logic                          i_word_valid,
    input logic [osm_pkg::STATUS_W-1:0]  i_status,
    input logic                          i_last,
    input logic [osm_pkg::FILL_W-1:0]    i_fill_level
);
    import osm_pkg::*;

    localparam int PAY_W = WORD_W + 1 + STATUS_W + 1 + FILL_W;

    logic [PAY_W-1:0] payload;
    logic             res_stalled;
    logic             res_word;
    logic             res_empty;
    logic             res_mid;
    logic             status_ok;

    assign payload     = {i_word_out, i_word_valid, i_status, i_last, i_fill_level};
    assign res_stalled = i_res_valid && !i_res_ready;
    assign res_word    = i_res_valid && i_word_valid;
    assign res_empty   = i_res_valid && !i_word_valid;
    assign res_mid     = i_res_valid && !i_last;
    assign status_ok   = (i_status == ST_OK);

    // a stalled result keeps its payload
    `OSM_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_stalled, i_res_valid && $stable(payload))

    // a word is only delivered by a request that succeeded
    `OSM_ASSERT_IMPLIES(a_word_ok, i_clk, i_rst_n, res_word, status_ok)

    // results without a word carry zero
    `OSM_ASSERT_IMPLIES(a_word_zero, i_clk, i_rst_n, res_empty, i_word_out == '0)

    // only output-k bursts have results before the last
    `OSM_ASSERT_IMPLIES(a_burst_word, i_clk, i_rst_n, res_mid, i_word_valid && status_ok)

endmodule

bind operand_stack_machine osm_checker u_osm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_word_out   (o_res.word_out),
    .i_word_valid (o_res.word_valid),
    .i_status     (o_res.status),
    .i_last       (o_res.last),
    .i_fill_level (o_res.fill_level)
);

FILE: test/operand_stack_machine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Operand stack machine testbench
// Runs a table of directed commands, then fills the stack to its limit while
// the result side is held off, then sends random command mixes that grow,
// shrink and churn the stack. A stack predictor in this file computes the
// results due for each accepted request, and every result is checked in order.
// ----------------------------------------------------------------------------
module operand_stack_machine_tb;
    import osm_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 360;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int DUE_SIZE     = 1024;

    // spare opcodes decode as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd13;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word WORD_MIN = 64'h8000_0000_0000_0000;
    localparam t_res  NO_WANT  = '0;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_CHURN
    } t_mix;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        t_word             value;
        logic [TAKE_W-1:0] take;
        bit                typed;
        t_res              want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    osm_cmd_if cmd_if ();
    osm_res_if res_if ();

    operand_stack_machine #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted stack state
    t_word       stack_words [STACK_DEPTH];
    int unsigned base_slot;
    int unsigned depth_now;

    // results still to come, in order, as a ring
    t_res        due_ring [DUE_SIZE];
    int unsigned due_wr;
    int unsigned due_rd;
    // results of the command just predicted
    t_res        cmd_res [MAX_RESULTS];
    int          cmd_res_n;
    int          n_mismatch;
    bit          hold_off_req;
    bit          tx_free;

    // rows with a want field are checked against that literal result
    t_row dir_rows [26] = '{
        '{CMD_POP,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_PEEK,     64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_OUTPUT,   64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_DUP,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_ROT,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_REVROT,   64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_NEG,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_EMPTY, 1'b1, 7'd0}},
        '{CMD_SWAP,     64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_FEW,   1'b1, 7'd0}},
        '{CMD_OUTK,     64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_OK,    1'b1, 7'd0}},
        '{CMD_OUTK,     64'd0,    7'd127, 1'b1, '{64'd0, 1'b0, ST_FEW,   1'b1, 7'd0}},
        '{CMD_PUSH_VAL, WORD_MAX, 7'd0,   1'b1, '{64'd0, 1'b0, ST_OK,    1'b1, 7'd1}},
        '{CMD_ADD,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_FEW,   1'b1, 7'd1}},
        '{CMD_MUL,      64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_FEW,   1'b1, 7'd1}},
        '{CMD_PUSH_VAL, WORD_MIN, 7'd0,   1'b1, '{64'd0, 1'b0, ST_OK,    1'b1, 7'd2}},
        '{CMD_PEEK,     64'd0,    7'd0,   1'b1, '{WORD_MIN, 1'b1, ST_OK, 1'b1, 7'd2}},
        '{CMD_SWAP,     64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_PEEK,     64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_MUL,      64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_PUSH_ONE, 64'd0,    7'd0,   1'b1, '{64'd0, 1'b0, ST_OK,    1'b1, 7'd2}},
        '{CMD_NEG,      64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_ADD,      64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_DUP,      64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_ROT,      64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_REVROT,   64'd0,    7'd0,   1'b0, NO_WANT},
        '{CMD_SPARE_LAST, 64'd0,  7'd0,   1'b1, '{64'd0, 1'b0, ST_OK,    1'b1, 7'd2}},
        '{CMD_OUTK,     64'd0,    7'd2,   1'b0, NO_WANT}
    };

    function automatic void book_due(t_res r);
        due_ring[due_wr % DUE_SIZE] = r;
        due_wr++;
    endfunction

    function automatic int unsigned due_left();
        return due_wr - due_rd;
    endfunction

    function automatic void add_cmd_res(t_res r);
        cmd_res[cmd_res_n] = r;
        cmd_res_n++;
    endfunction

    function automatic int unsigned slot_at(int unsigned pos);
        return (base_slot + pos) % STACK_DEPTH;
    endfunction

    function automatic t_word top_word();
        return stack_words[slot_at(depth_now - 1)];
    endfunction

    function automatic void push_word(t_word w);
        stack_words[slot_at(depth_now)] = w;
        depth_now++;
    endfunction

    function automatic t_res make_res(t_word w, logic v, logic [STATUS_W-1:0] st, logic l);
        t_res r;
        r.word       = w;
        r.word_valid = v;
        r.status     = st;
        r.last       = l;
        r.fill       = FILL_W'(depth_now);
        return r;
    endfunction

    // updates the predicted stack and fills cmd_res with what one command causes
    task automatic apply_stack_cmd(input logic [CMD_W-1:0] c, input t_word pv,
                                   input logic [TAKE_W-1:0] k);
        t_word               a;
        t_word               b;
        t_word               w;
        logic                v;
        logic [STATUS_W-1:0] st;
        int unsigned         start;
        st        = ST_OK;
        w         = '0;
        v         = 1'b0;
        cmd_res_n = 0;
        case (c)
            CMD_PUSH_ONE, CMD_PUSH_VAL: begin
                if (depth_now >= STACK_DEPTH) st = ST_FULL;
                else push_word(c == CMD_PUSH_ONE ? 64'd1 : pv);
            end
            CMD_POP: begin
                if (depth_now == 0) st = ST_EMPTY;
                else depth_now--;
            end
            CMD_PEEK, CMD_OUTPUT: begin
                if (depth_now == 0) begin
                    st = ST_EMPTY;
                end else begin
                    w = top_word();
                    v = 1'b1;
                    if (c == CMD_OUTPUT) depth_now--;
                end
            end
            CMD_DUP: begin
                if (depth_now == 0) st = ST_EMPTY;
                else if (depth_now >= STACK_DEPTH) st = ST_FULL;
                else push_word(top_word());
            end
            CMD_SWAP, CMD_ADD, CMD_MUL: begin
                if (depth_now < 2) begin
                    st = ST_FEW;
                end else begin
                    a = stack_words[slot_at(depth_now - 1)];
                    b = stack_words[slot_at(depth_now - 2)];
                    if (c == CMD_SWAP) begin
                        stack_words[slot_at(depth_now - 1)] = b;
                        stack_words[slot_at(depth_now - 2)] = a;
                    end else begin
                        depth_now -= 2;
                        push_word(c == CMD_ADD ? a + b : a * b);
                    end
                end
            end
            CMD_ROT: begin
                if (depth_now == 0) begin
                    st = ST_EMPTY;
                end else begin
                    a = top_word();
                    base_slot = (base_slot + STACK_DEPTH - 1) % STACK_DEPTH;
                    stack_words[base_slot] = a;
                end
            end
            CMD_REVROT: begin
                if (depth_now == 0) begin
                    st = ST_EMPTY;
                end else begin
                    a = stack_words[base_slot];
                    base_slot = (base_slot + 1) % STACK_DEPTH;
                    stack_words[slot_at(depth_now - 1)] = a;
                end
            end
            CMD_NEG: begin
                if (depth_now == 0) st = ST_EMPTY;
                else stack_words[slot_at(depth_now - 1)] = t_word'(0) - top_word();
            end
            CMD_OUTK: begin
                if (k > depth_now || k > MAX_RESULTS) begin
                    st = ST_FEW;
                end else if (k != 0) begin
                    start = depth_now;
                    depth_now -= k;
                    for (int i = 0; i < k; i++)
                        add_cmd_res(make_res(stack_words[slot_at(start - 1 - i)],
                                             1'b1, ST_OK, i + 1 == k));
                    return;
                end
            end
            default: ;
        endcase
        add_cmd_res(make_res(w, v, st, 1'b1));
    endtask

    // holds the request until it is taken; returns at the accepting edge
    task automatic send_cmd(input logic [CMD_W-1:0] c, input t_word pv,
                            input logic [TAKE_W-1:0] k);
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= c;
        cmd_if.push_value <= pv;
        cmd_if.take_count <= k;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_free || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return WORD_MAX;
            3: return WORD_MIN;
            4: return t_word'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(t_mix mix);
        int push_pct;
        int pop_pct;
        int r;
        push_pct = (mix == MIX_GROW) ? 55 : (mix == MIX_SHRINK) ? 15 : 30;
        pop_pct  = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 45 : 25;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 3) == 0) ? CMD_PUSH_ONE : CMD_PUSH_VAL;
        if (r < push_pct + pop_pct) begin
            case ($urandom_range(0, 2))
                0: return CMD_POP;
                1: return CMD_OUTPUT;
                default: return CMD_OUTK;
            endcase
        end
        if ($urandom_range(0, 29) == 0)
            return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        case ($urandom_range(0, 7))
            0: return CMD_PEEK;
            1: return CMD_DUP;
            2: return CMD_SWAP;
            3: return CMD_ROT;
            4: return CMD_REVROT;
            5: return CMD_ADD;
            6: return CMD_MUL;
            default: return CMD_NEG;
        endcase
    endfunction

    // send one request, book its results, then idle for a gap set by n
    task automatic issue(input logic [CMD_W-1:0] c, input t_word pv,
                         input logic [TAKE_W-1:0] k, input int n);
        send_cmd(c, pv, k);
        apply_stack_cmd(c, pv, k);
        for (int j = 0; j < cmd_res_n; j++) book_due(cmd_res[j]);
        sender_gap(n);
    endtask

    task automatic check_result();
        t_res got;
        t_res want;
        got = '{res_if.word_out, res_if.word_valid, res_if.status, res_if.last,
                res_if.fill_level};
        if (due_left() == 0) begin
            $error("result with nothing due: word_out %h status %0d",
                   got.word, got.status);
            n_mismatch++;
            return;
        end
        want = due_ring[due_rd % DUE_SIZE];
        due_rd++;
        if (got.word !== want.word) begin
            $error("word_out: expected %h, got %h", want.word, got.word);
            n_mismatch++;
        end
        if (got.word_valid !== want.word_valid) begin
            $error("word_valid: expected %0d, got %0d", want.word_valid, got.word_valid);
            n_mismatch++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_mismatch++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            n_mismatch++;
        end
        if (got.fill !== want.fill) begin
            $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
            n_mismatch++;
        end
    endtask

    // result side: random back-pressure, free-running windows, long hold-off
    initial begin : result_sink
        int stall_left;
        int cyc;
        bit rx_free;
        int r;
        stall_left   = 0;
        cyc          = 0;
        rx_free      = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) check_result();
            cyc++;
            if (cyc % 128 == 0) rx_free = ($urandom_range(0, 3) == 0);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (rx_free || r < 70) begin
                    res_if.ready <= 1'b1;
                end else begin
                    stall_left   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                    res_if.ready <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_mix              mix;
        logic [CMD_W-1:0]  c;
        logic [TAKE_W-1:0] k;
        int                lim;
        n_mismatch        = 0;
        hold_off_req      = 1'b0;
        tx_free           = 1'b0;
        base_slot         = 0;
        depth_now         = 0;
        due_wr            = 0;
        due_rd            = 0;
        cmd_res_n         = 0;
        mix               = MIX_CHURN;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = CMD_PUSH_ONE;
        cmd_if.push_value = '0;
        cmd_if.take_count = '0;
        foreach (stack_words[i]) stack_words[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].take);
            apply_stack_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].take);
            if (dir_rows[i].typed)
                book_due(dir_rows[i].want);
            else
                for (int j = 0; j < cmd_res_n; j++) book_due(cmd_res[j]);
            sender_gap(pick_gap());
        end

        // let the block drain completely before the fill run
        cmd_if.valid <= 1'b0;
        while (due_left() != 0) @(posedge i_clk);

        // fill to the top while results are held off, so the input stalls
        hold_off_req = 1'b1;
        while (depth_now < STACK_DEPTH)
            issue(CMD_PUSH_VAL, pick_word(), TAKE_W'($urandom), 0);
        issue(CMD_PUSH_ONE, pick_word(), 7'd0, 0);
        issue(CMD_PUSH_VAL, WORD_MAX, 7'd0, 0);
        issue(CMD_DUP, '0, 7'd0, 0);
        issue(CMD_ROT, '0, 7'd0, 0);
        issue(CMD_REVROT, '0, 7'd0, 0);
        issue(CMD_SWAP, '0, 7'd0, 0);
        issue(CMD_NEG, '0, 7'd0, 0);
        issue(CMD_OUTK, '0, 7'd65, 0);
        issue(CMD_OUTK, '0, 7'd64, pick_gap());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) mix = t_mix'($urandom_range(0, 2));
            if (n % 40 == 0) tx_free = ($urandom_range(0, 3) == 0);
            c = pick_cmd(mix);
            k = TAKE_W'($urandom);
            if (c == CMD_OUTK && $urandom_range(0, 4) != 0) begin
                lim = (depth_now < MAX_RESULTS) ? int'(depth_now) : MAX_RESULTS;
                k   = TAKE_W'($urandom_range(0, lim));
            end
            issue(c, (c == CMD_PUSH_VAL) ? pick_word() : {$urandom, $urandom}, k,
                  pick_gap());
        end

        cmd_if.valid <= 1'b0;
        while (due_left() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: operand_stack_machine.f
+incdir+sv
sv/osm_pkg.sv
sv/osm_if.sv
sv/osm_front.sv
sv/osm_queue.sv
sv/osm_back.sv
sv/operand_stack_machine.sv
sv/osm_checker.sv
test/operand_stack_machine_tb.sv
